// File: rtl/aae_pkg.sv
// ----------------------------------------------------------------------------
// aae_pkg
// shared types and constants for the adaptive arithmetic encoder
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam int COUNT_BITS = 24;
    localparam int ALPHABET   = 256;
    localparam int RANGE_BITS = 32;

    localparam int SYM_W    = 8;
    localparam int PEND_W   = 30;
    localparam int FOLLOW_W = 31;
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef enum logic [3:0] {
        C_IDLE,
        C_WALK,
        C_CNT,
        C_MLO,
        C_WLO,
        C_MHI,
        C_WHI,
        C_UPD,
        C_RENORM,
        C_FLUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic accept;
        logic walk;
        logic latch_cnt;
        logic md_start;
        logic sel_hi;
        logic save_lo;
        logic update;
        logic renorm;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic md_done;
        logic renorm_done;
        logic out_free;
        logic last;
    } dp_status_t;

endpackage

// File: rtl/aae_muldiv.sv
// ----------------------------------------------------------------------------
// aae_muldiv
// sequential a*b/d: shift-add multiply, then restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module aae_muldiv #(
    parameter int RW = 33,
    parameter int CW = 25
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [RW-1:0] a,
    input  logic [CW-1:0] b,
    input  logic [CW-1:0] d,
    output logic          done,
    output logic [RW-1:0] q
);

    localparam int PW = RW + CW;
    localparam int NW = $clog2(PW);

    aae_pkg::md_state_t state_reg, state_next;

    logic [PW-1:0] acc_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] b_reg;
    logic [CW-1:0] d_reg;
    logic [RW-1:0] a_reg;
    logic [NW-1:0] cnt_reg;
    logic          done_reg;

    logic [CW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, acc_reg[PW-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aae_pkg::MD_IDLE: if (start) state_next = aae_pkg::MD_MUL;
            aae_pkg::MD_MUL:  if (cnt_reg == NW'(CW - 1)) state_next = aae_pkg::MD_DIV;
            aae_pkg::MD_DIV:  if (cnt_reg == NW'(PW - 1)) state_next = aae_pkg::MD_IDLE;
            default:          state_next = aae_pkg::MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aae_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == aae_pkg::MD_DIV) && (cnt_reg == NW'(PW - 1));
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            aae_pkg::MD_IDLE: begin
                if (start) begin
                    a_reg   <= a;
                    b_reg   <= b;
                    d_reg   <= d;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            aae_pkg::MD_MUL: begin
                acc_reg <= (acc_reg << 1) + (b_reg[CW-1] ? {{CW{1'b0}}, a_reg} : '0);
                b_reg   <= b_reg << 1;
                if (cnt_reg == NW'(CW - 1)) begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            aae_pkg::MD_DIV: begin
                // dividend shifts out the top while quotient bits fill the bottom
                rem_reg <= ge ? CW'(trial - {1'b0, d_reg}) : trial[CW-1:0];
                acc_reg <= {acc_reg[PW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign q    = acc_reg[RW-1:0];

endmodule

// File: rtl/aae_dp.sv
// ----------------------------------------------------------------------------
// aae_dp
// encoder datapath: count store, interval registers, renormalisation, output
// ----------------------------------------------------------------------------
module aae_dp #(
    parameter int COUNT_BITS = aae_pkg::COUNT_BITS,
    parameter int ALPHABET   = aae_pkg::ALPHABET,
    parameter int RANGE_BITS = aae_pkg::RANGE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  aae_pkg::ctrl_cmd_t         cmd,
    output aae_pkg::dp_status_t        status,
    input  logic [aae_pkg::SYM_W-1:0]  sym_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_lead,
    output logic [aae_pkg::FOLLOW_W-1:0] out_follow,
    output logic                       out_last
);

    localparam int CW = COUNT_BITS + 1;
    localparam int RW = RANGE_BITS + 1;
    localparam int AW = $clog2(ALPHABET);
    localparam int SW = $clog2(RANGE_BITS + 1);
    localparam int PEND_W = aae_pkg::PEND_W;
    localparam int FOLLOW_W = aae_pkg::FOLLOW_W;
    localparam int SYM_W = aae_pkg::SYM_W;

    localparam logic [RW-1:0] Q4 = RW'(1) << RANGE_BITS;
    localparam logic [RW-1:0] Q2 = Q4 >> 1;
    localparam logic [RW-1:0] Q1 = Q4 >> 2;
    localparam logic [RW-1:0] Q3 = Q2 + Q1;
    localparam logic [CW-1:0] CNT_LIM = CW'(1) << COUNT_BITS;
    localparam logic [CW-1:0] TOTAL_INIT = CW'(ALPHABET);
    localparam logic [SYM_W:0] SYM_MAX = (SYM_W + 1)'(ALPHABET - 1);

    logic [CW-1:0] mem [ALPHABET];
    logic [ALPHABET-1:0] valid_reg;
    logic [CW-1:0] rd_reg;
    logic          rdv_reg;
    logic [CW-1:0] rdval;

    logic [AW-1:0] sym_reg, idx_reg;
    logic          last_reg, add_reg;
    logic [CW-1:0] cum_reg, cnt_reg, total_reg;
    logic [RW-1:0] low_reg, high_reg, width_reg, qlo_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [SW-1:0] steps_reg;

    logic          ov_reg, olead_reg, olast_reg;
    logic [FOLLOW_W-1:0] ofollow_reg;

    logic [AW-1:0] sym_sat;
    logic          md_done;
    logic [RW-1:0] md_q;
    logic          upper, emit, under, stop, out_free, flush_c, load_out;
    logic [RW-1:0] off;

    assign sym_sat = ({1'b0, sym_in} > SYM_MAX) ? SYM_MAX[AW-1:0] : sym_in[AW-1:0];
    assign rdval   = rdv_reg ? rd_reg : CW'(1);

    aae_muldiv #(.RW(RW), .CW(CW)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .a       (width_reg),
        .b       (cmd.sel_hi ? CW'(cum_reg + cnt_reg) : cum_reg),
        .d       (total_reg),
        .done    (md_done),
        .q       (md_q)
    );

    assign upper    = low_reg >= Q2;
    assign emit     = upper || (high_reg <= Q2);
    assign under    = !((low_reg < Q1) || (high_reg > Q3));
    assign stop     = (steps_reg == SW'(RANGE_BITS)) || (!emit && !under);
    assign off      = upper ? Q2 : '0;
    assign out_free = !ov_reg || out_ready;
    assign flush_c  = (low_reg <= Q1) && (high_reg >= Q2);
    assign load_out = (cmd.renorm && !stop && emit && out_free) || (cmd.flush && out_free);

    assign status.walk_done   = idx_reg == sym_reg;
    assign status.md_done     = md_done;
    assign status.renorm_done = stop;
    assign status.out_free    = out_free;
    assign status.last        = last_reg;

    // count store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.update && total_reg < CNT_LIM) begin
            mem[sym_reg] <= cnt_reg + 1'b1;
        end
        rd_reg  <= mem[idx_reg];
        rdv_reg <= valid_reg[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sym_reg  <= sym_sat;
            last_reg <= last_in;
        end
        if (cmd.latch_cnt) begin
            cnt_reg   <= rdval;
            width_reg <= high_reg - low_reg;
        end
        if (cmd.save_lo) begin
            qlo_reg <= md_q;
        end
        if (load_out) begin
            olead_reg   <= cmd.flush ? ~flush_c : upper;
            ofollow_reg <= cmd.flush ? FOLLOW_W'({1'b0, pend_reg} + 1'b1)
                                     : {1'b0, pend_reg};
            olast_reg   <= cmd.flush;
        end
    end

    // walk: read entry idx, add it in the following cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= '0;
            cum_reg <= '0;
            add_reg <= 1'b0;
        end else begin
            if (add_reg) cum_reg <= cum_reg + rdval;
            if (cmd.walk) begin
                add_reg <= idx_reg != sym_reg;
                if (idx_reg != sym_reg) idx_reg <= idx_reg + 1'b1;
            end else begin
                add_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            total_reg <= TOTAL_INIT;
            low_reg   <= '0;
            high_reg  <= Q4;
            pend_reg  <= '0;
            steps_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            if (load_out) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;

            if (cmd.update) begin
                low_reg   <= low_reg + qlo_reg;
                high_reg  <= low_reg + md_q;
                steps_reg <= '0;
                if (total_reg < CNT_LIM) begin
                    total_reg          <= total_reg + 1'b1;
                    valid_reg[sym_reg] <= 1'b1;
                end
            end

            if (cmd.renorm && !stop) begin
                if (emit) begin
                    if (out_free) begin
                        pend_reg  <= '0;
                        low_reg   <= RW'((low_reg - off) << 1);
                        high_reg  <= RW'((high_reg - off) << 1);
                        steps_reg <= steps_reg + 1'b1;
                    end
                end else begin
                    low_reg   <= RW'((low_reg - Q1) << 1);
                    high_reg  <= RW'((high_reg - Q1) << 1);
                    steps_reg <= steps_reg + 1'b1;
                    if (pend_reg != aae_pkg::PEND_MAX) pend_reg <= pend_reg + 1'b1;
                end
            end

            if (cmd.flush && out_free) begin
                valid_reg <= '0;
                total_reg <= TOTAL_INIT;
                low_reg   <= '0;
                high_reg  <= Q4;
                pend_reg  <= '0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign out_lead   = olead_reg;
    assign out_follow = ofollow_reg;
    assign out_last   = olast_reg;

`ifndef NO_ASSERTIONS
    a_interval_order: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= high_reg)
        else $error("interval low above high");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_LIM)
        else $error("total count beyond limit");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= SW'(RANGE_BITS))
        else $error("renormalisation step count overrun");
`endif

endmodule

// File: rtl/aae_ctrl.sv
// ----------------------------------------------------------------------------
// aae_ctrl
// encoder sequencer: walk, two scale operations, update, renormalise, flush
// ----------------------------------------------------------------------------
module aae_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  aae_pkg::dp_status_t status,
    output aae_pkg::ctrl_cmd_t  cmd
);

    aae_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aae_pkg::C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            aae_pkg::C_IDLE:   if (in_valid) state_next = aae_pkg::C_WALK;
            aae_pkg::C_WALK:   if (status.walk_done) state_next = aae_pkg::C_CNT;
            aae_pkg::C_CNT:    state_next = aae_pkg::C_MLO;
            aae_pkg::C_MLO:    state_next = aae_pkg::C_WLO;
            aae_pkg::C_WLO:    if (status.md_done) state_next = aae_pkg::C_MHI;
            aae_pkg::C_MHI:    state_next = aae_pkg::C_WHI;
            aae_pkg::C_WHI:    if (status.md_done) state_next = aae_pkg::C_UPD;
            aae_pkg::C_UPD:    state_next = aae_pkg::C_RENORM;
            aae_pkg::C_RENORM: begin
                if (status.renorm_done) begin
                    state_next = status.last ? aae_pkg::C_FLUSH : aae_pkg::C_IDLE;
                end
            end
            aae_pkg::C_FLUSH:  if (status.out_free) state_next = aae_pkg::C_IDLE;
            default:           state_next = aae_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            aae_pkg::C_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            aae_pkg::C_WALK:   cmd.walk = 1'b1;
            aae_pkg::C_CNT:    cmd.latch_cnt = 1'b1;
            aae_pkg::C_MLO:    cmd.md_start = 1'b1;
            aae_pkg::C_WLO:    cmd.save_lo = status.md_done;
            aae_pkg::C_MHI: begin
                cmd.md_start = 1'b1;
                cmd.sel_hi   = 1'b1;
            end
            aae_pkg::C_WHI:    cmd.sel_hi = 1'b1;
            aae_pkg::C_UPD:    cmd.update = 1'b1;
            aae_pkg::C_RENORM: cmd.renorm = 1'b1;
            aae_pkg::C_FLUSH:  cmd.flush = 1'b1;
            default: ;
        endcase
    end

endmodule

// File: rtl/adaptive_arithmetic_encoder_top.sv
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder_top
// adaptive order-0 arithmetic coder, one byte in, code bit runs out
// ----------------------------------------------------------------------------
// usage
//   s_ side: one byte per beat in s_tdata, s_tlast marks the final byte of a
//   message. m_ side: each beat is one code bit (m_tdata[0]) followed by
//   m_tdata[31:1] bits of the opposite value; m_tlast marks the flush beat
//   that closes a message.
// timing
//   one byte at a time. the count walk reads one entry of the count store per
//   cycle, and the shared multiply/divide unit takes one multiplier bit per
//   cycle, then one dividend bit per cycle. code beats are loaded during
//   renormalisation and the flush of a message's last byte, after the scale
//   steps.
// reset and stall
//   aresetn (synchronous, active low) sets all counts to one, the total to
//   the alphabet size and the interval to full width; a flush does the same.
//   while m_tready is low a held output beat stays put and renormalisation
//   waits to emit; s_tready stays low until the byte is finished.
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_top #(
    parameter int COUNT_BITS = aae_pkg::COUNT_BITS,
    parameter int ALPHABET   = aae_pkg::ALPHABET,
    parameter int RANGE_BITS = aae_pkg::RANGE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] lead_bit, [31:1] follow_count
    output logic        m_tlast
);

    aae_pkg::ctrl_cmd_t  cmd;
    aae_pkg::dp_status_t status;
    logic                lead;
    logic [aae_pkg::FOLLOW_W-1:0] follow;

    aae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aae_dp #(
        .COUNT_BITS (COUNT_BITS),
        .ALPHABET   (ALPHABET),
        .RANGE_BITS (RANGE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .sym_in     (s_tdata),
        .last_in    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_lead   (lead),
        .out_follow (follow),
        .out_last   (m_tlast)
    );

    assign m_tdata = {follow, lead};

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("byte accepted while previous one in flight");

    a_flush_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[31:1] != 31'd0)
        else $error("flush beat without trailing bits");
`endif

endmodule

// File: tb/sv/aae_code_checker.sv
// ----------------------------------------------------------------------------
// aae_code_checker
// watches both streams of the arithmetic encoder, predicts the code bit beats
// of every accepted byte and compares them in order with the output beats
// ----------------------------------------------------------------------------
module aae_code_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          beats_owed
);

    localparam logic [32:0] QTR  = 33'h040000000;
    localparam logic [32:0] HALF = 33'h080000000;
    localparam logic [32:0] TQTR = 33'h0c0000000;
    localparam logic [32:0] FULL = 33'h100000000;

    typedef struct packed {
        logic                         bit_val;
        logic [aae_pkg::FOLLOW_W-1:0] follow;
        logic                         last;
    } code_beat_t;

    code_beat_t  code_q[$];
    logic [24:0] freq[aae_pkg::ALPHABET];
    logic [24:0] freq_sum;
    logic [32:0] lo_b, hi_b;
    logic [aae_pkg::PEND_W-1:0] pend;

    assign beats_owed = code_q.size();

    function automatic void coder_clear();
        for (int i = 0; i < aae_pkg::ALPHABET; i++) freq[i] = 1;
        freq_sum = aae_pkg::ALPHABET;
        lo_b = 0;
        hi_b = FULL;
        pend = 0;
    endfunction

    function automatic void encode_byte(input logic [7:0] sym_in, input logic fin);
        int unsigned sym;
        logic [63:0] cum, span;
        logic [32:0] off;
        logic        up, c;
        code_beat_t  b;
        sym = (sym_in >= aae_pkg::ALPHABET) ? aae_pkg::ALPHABET - 1 : sym_in;
        cum = 0;
        for (int i = 0; i < sym; i++) cum += freq[i];
        span = hi_b - lo_b;
        hi_b = lo_b + (span * (cum + freq[sym])) / freq_sum;
        lo_b = lo_b + (span * cum) / freq_sum;
        if (freq_sum < (25'd1 << aae_pkg::COUNT_BITS)) begin
            freq[sym]++;
            freq_sum++;
        end
        for (int k = 0; k < aae_pkg::RANGE_BITS; k++) begin
            up = lo_b >= HALF;
            if (up || hi_b <= HALF) begin
                off = up ? HALF : 33'd0;
                b.bit_val = up;
                b.follow  = aae_pkg::FOLLOW_W'(pend);
                b.last    = 1'b0;
                code_q = {code_q, b};
                pend = 0;
                lo_b = (lo_b - off) << 1;
                hi_b = (hi_b - off) << 1;
                continue;
            end
            if (lo_b < QTR || hi_b > TQTR) break;
            lo_b = (lo_b - QTR) << 1;
            hi_b = (hi_b - QTR) << 1;
            if (pend != aae_pkg::PEND_MAX) pend++;
        end
        if (fin) begin
            c = (lo_b <= QTR) && (hi_b >= HALF);
            b.bit_val = ~c;
            b.follow  = aae_pkg::FOLLOW_W'(pend) + 1;
            b.last    = 1'b1;
            code_q = {code_q, b};
            coder_clear();
        end
    endfunction

    always @(posedge aclk) begin
        code_beat_t e;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            coder_clear();
            code_q.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (code_q.size() == 0) begin
                    $error("output beat with nothing expected: %h", m_tdata);
                    errs++;
                end else begin
                    e = code_q.pop_front();
                    if (m_tdata[0] !== e.bit_val) begin
                        $error("lead_bit: expected %0d got %0d", e.bit_val, m_tdata[0]);
                        errs++;
                    end
                    if (m_tdata[31:1] !== e.follow) begin
                        $error("follow_count: expected %0d got %0d", e.follow,
                               m_tdata[31:1]);
                        errs++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_out: expected %0d got %0d", e.last, m_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// File: tb/sv/adaptive_arithmetic_encoder_top_test.sv
// ----------------------------------------------------------------------------
// adaptive_arithmetic_encoder_top_test
// drives byte messages into the encoder under varying idle and stall
// patterns, including a long output hold-off; the checker compares results
// ----------------------------------------------------------------------------
module adaptive_arithmetic_encoder_top_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          beats_owed;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_off = 0;
    logic        hold_start = 1'b0;
    logic        hold_done = 1'b0;
    int          quiet_cycles = 0;

    always #5 aclk = ~aclk;

    adaptive_arithmetic_encoder_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    aae_code_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .beats_owed(beats_owed)
    );

    // receiver: random stalls, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (hold_start && !hold_done) begin
            hold_off  <= 3000;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] sym, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (beats_owed != 0) @(negedge aclk);
    endtask

    task automatic random_message(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(alpha)), i == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes, a one-byte message, repeated symbol, flush
        send_byte(8'd0, 1'b1);
        send_byte(8'd255, 1'b1);
        send_byte(8'd128, 1'b0);
        send_byte(8'd127, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd254, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        for (int i = 0; i < 12; i++) send_byte(8'd0, i == 11);
        for (int i = 0; i < 4; i++) send_byte(8'd255, i == 3);
        drain();
        sent = 24;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 75 : 15) : 0;
            stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 75 : 15) : 0;
            if (ph == 0) hold_start = 1'b1;
            for (int m = 0; m < 8; m++) begin
                len = $urandom_range(18, 1);
                // narrow alphabets drive skewed counts and long pending runs
                random_message(len, ($urandom_range(3) == 0) ? 3 : 255);
                sent += len;
            end
            drain();
        end
        while (sent < 370) begin
            len = $urandom_range(20, 1);
            random_message(len, $urandom_range(255, 1));
            sent += len;
        end
        drain();
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && beats_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
rtl/aae_pkg.sv
rtl/aae_muldiv.sv
rtl/aae_dp.sv
rtl/aae_ctrl.sv
rtl/adaptive_arithmetic_encoder_top.sv
tb/sv/aae_code_checker.sv
tb/sv/adaptive_arithmetic_encoder_top_test.sv
